// ===== rtl/vision_circle_grid_stamper_defines.svh =====
// assertion macros used by the stamper datapath
`ifndef VISION_CIRCLE_GRID_STAMPER_DEFINES_SVH
`define VISION_CIRCLE_GRID_STAMPER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define VCGS_ASSERT_IMPL(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("vcgs assertion failed");

// next-cycle implication, disabled while reset is asserted
`define VCGS_ASSERT_NEXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("vcgs assertion failed");

`endif

// ===== rtl/vcgs_pkg.sv =====
`timescale 1ns / 1ps

package vcgs_pkg;

    // grid geometry, side is a power of two
    localparam int GRID_SIDE  = 128;
    localparam int COORD_W    = $clog2(GRID_SIDE);
    localparam int CRD_W      = COORD_W + 1;
    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;

    // field widths
    localparam int IDX_W      = 14;
    localparam int IDX_LIM_W  = IDX_W + 1;
    localparam int VAL_W      = 24;
    localparam int CNT_W      = 16;
    localparam int CELL_W     = 8;
    localparam int CFG_IDX_W  = 1;

    // fixed point datapath widths (grid values in Q.24)
    localparam int MUL_W      = VAL_W + 1;
    localparam int G_W        = 2 * MUL_W;
    localparam int E_W        = G_W + 1;
    localparam int FRAC_SHIFT = 24;
    localparam int Q_W        = E_W - FRAC_SHIFT;
    localparam int HALF_W     = 25;
    localparam int MAG_W      = 2 * HALF_W;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int SQX_W      = SQ_W + 2;
    localparam int SLK_W      = SQ_W + 1;

    // one cell step in Q.24 and the matching square increment
    localparam logic signed [E_W-1:0]   E_STEP  = E_W'(64'sd16777216);
    localparam logic signed [SQX_W-1:0] SQ_STEP = SQX_W'(64'sd281474976710656);

    localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
    localparam logic [CELL_W-1:0] CELL_ON   = 8'hFF;
    localparam logic [CELL_W-1:0] CELL_OFF  = 8'h00;
    localparam logic [VAL_W-1:0]  INV_RESET = 24'd65536;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV    = 1'b1;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_STAMP = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0]              req_type;
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] sight_radius;
        logic [7:0]              team_id;
        logic [IDX_W-1:0]        cell_index;
    } t_in;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [CNT_W-1:0]  source_count;
    } t_out;

    typedef enum logic [1:0] {
        G_X,
        G_Z,
        G_R
    } t_gsel;

    typedef enum logic [1:0] {
        SQ_R,
        SQ_X,
        SQ_Z
    } t_sqsel;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_GMUL_X,
        ST_GMUL_Z,
        ST_GMUL_R,
        ST_RANGE,
        ST_CHECK,
        ST_SQ_R,
        ST_SQ_X,
        ST_SQ_Z,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_CELL,
        ST_ROW_WR,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic   load;
        logic   g_en;
        t_gsel  g_sel;
        logic   range_en;
        logic   prep_en;
        logic   sq_start;
        t_sqsel sq_sel;
        logic   clr_wr;
        logic   row_rd;
        logic   row_load;
        logic   cell_en;
        logic   row_wr;
        logic   z_next;
        logic   rd_issue;
        logic   rd_load;
        logic   out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       stamp_ok;
        logic       empty;
        logic       sq_done;
        logic       x_last;
        logic       z_last;
        logic       sweep_last;
        logic       out_free;
    } t_dp_status;

endpackage

// ===== rtl/vcgs_ram.sv =====
`timescale 1ns / 1ps

module vcgs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vcgs_sq.sv =====
`timescale 1ns / 1ps

// squares a signed value over three partial products, one per cycle
module vcgs_sq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [vcgs_pkg::E_W-1:0]   i_operand,
    output logic                              o_busy,
    output logic                              o_done,
    output logic [vcgs_pkg::SQ_W-1:0]         o_square
);

    logic [2:0]                         r_step;
    logic                               r_done;
    logic [vcgs_pkg::HALF_W-1:0]        r_h;
    logic [vcgs_pkg::HALF_W-1:0]        r_l;
    logic [vcgs_pkg::MAG_W-1:0]         r_p;
    logic [vcgs_pkg::SQ_W-1:0]          r_acc;
    logic signed [vcgs_pkg::E_W-1:0]    neg_op;
    logic [vcgs_pkg::MAG_W-1:0]         mag;
    logic [vcgs_pkg::HALF_W-1:0]        mul_a;
    logic [vcgs_pkg::HALF_W-1:0]        mul_b;
    logic [vcgs_pkg::MAG_W-1:0]         prod;

    always_comb begin
        neg_op = -i_operand;
        mag    = i_operand[vcgs_pkg::E_W-1] ? neg_op[vcgs_pkg::MAG_W-1:0]
                                            : i_operand[vcgs_pkg::MAG_W-1:0];
        // low*low, then high*low, then high*high
        mul_a  = (r_step == 3'd3) ? r_h : r_l;
        mul_b  = (r_step == 3'd1) ? r_l : r_h;
        prod   = vcgs_pkg::MAG_W'(mul_a) * vcgs_pkg::MAG_W'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == 3'd4);
            if (r_step == 3'd0) begin
                if (i_start) begin
                    r_step <= 3'd1;
                end
            end else if (r_step == 3'd4) begin
                r_step <= 3'd0;
            end else begin
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_step)
            3'd0: begin
                if (i_start) begin
                    r_h <= mag[vcgs_pkg::MAG_W-1:vcgs_pkg::HALF_W];
                    r_l <= mag[vcgs_pkg::HALF_W-1:0];
                end
            end
            3'd1: begin
                r_p <= prod;
            end
            3'd2: begin
                r_acc <= vcgs_pkg::SQ_W'(r_p);
                r_p   <= prod;
            end
            3'd3: begin
                r_acc <= r_acc + (vcgs_pkg::SQ_W'(r_p) << (vcgs_pkg::HALF_W + 1));
                r_p   <= prod;
            end
            3'd4: begin
                r_acc <= r_acc + {r_p, {vcgs_pkg::MAG_W{1'b0}}};
            end
            default: begin
            end
        endcase
    end

    assign o_busy   = (r_step != 3'd0);
    assign o_done   = r_done;
    assign o_square = r_acc;

endmodule

// ===== rtl/vcgs_dp.sv =====
`timescale 1ns / 1ps
`include "vision_circle_grid_stamper_defines.svh"

module vcgs_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  vcgs_pkg::t_in                         i_in_data,
    input  logic                                  i_cfg_wr_en,
    input  logic [vcgs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [vcgs_pkg::VAL_W-1:0]            i_cfg_wdata,
    input  vcgs_pkg::t_dp_cmd                     i_cmd,
    output vcgs_pkg::t_dp_status                  o_status,
    output logic                                  o_out_valid,
    output vcgs_pkg::t_out                        o_out_data,
    input  logic                                  i_out_stall
);

    // configuration and counted state
    logic signed [vcgs_pkg::VAL_W-1:0]  r_origin;
    logic [vcgs_pkg::VAL_W-1:0]         r_inv;
    logic [vcgs_pkg::CNT_W-1:0]         r_count;
    logic [vcgs_pkg::CRD_W-1:0]         r_z;
    logic                               r_out_valid;

    // item and work registers
    logic signed [vcgs_pkg::VAL_W-1:0]  r_px;
    logic signed [vcgs_pkg::VAL_W-1:0]  r_pz;
    logic signed [vcgs_pkg::VAL_W-1:0]  r_rad;
    logic [vcgs_pkg::IDX_W-1:0]         r_idx;
    logic signed [vcgs_pkg::G_W-1:0]    r_gx;
    logic signed [vcgs_pkg::G_W-1:0]    r_gz;
    logic signed [vcgs_pkg::G_W-1:0]    r_gr;
    logic [vcgs_pkg::CRD_W-1:0]         r_x0;
    logic [vcgs_pkg::CRD_W-1:0]         r_x1;
    logic [vcgs_pkg::CRD_W-1:0]         r_z0;
    logic [vcgs_pkg::CRD_W-1:0]         r_z1;
    logic                               r_neg;
    logic signed [vcgs_pkg::E_W-1:0]    r_ex0;
    logic signed [vcgs_pkg::E_W-1:0]    r_ex;
    logic signed [vcgs_pkg::E_W-1:0]    r_ez;
    logic [vcgs_pkg::SQ_W-1:0]          r_rsq;
    logic [vcgs_pkg::SQ_W-1:0]          r_sqx0;
    logic [vcgs_pkg::SQ_W-1:0]          r_sqx;
    logic [vcgs_pkg::SQ_W-1:0]          r_sqz;
    logic signed [vcgs_pkg::SLK_W-1:0]  r_slack;
    vcgs_pkg::t_sqsel                   r_sq_dst;
    logic [vcgs_pkg::CRD_W-1:0]         r_x;
    logic [vcgs_pkg::GRID_SIDE-1:0]     r_row;
    logic                               r_cell;
    vcgs_pkg::t_out                     r_out;

    logic signed [vcgs_pkg::MUL_W-1:0]  op_a;
    logic signed [vcgs_pkg::MUL_W-1:0]  op_b;
    logic signed [vcgs_pkg::G_W-1:0]    g_prod;
    logic signed [vcgs_pkg::E_W-1:0]    a_x;
    logic signed [vcgs_pkg::E_W-1:0]    b_x;
    logic signed [vcgs_pkg::E_W-1:0]    a_z;
    logic signed [vcgs_pkg::E_W-1:0]    b_z;
    logic signed [vcgs_pkg::E_W-1:0]    sq_operand;
    logic                               sq_busy;
    logic                               sq_done;
    logic [vcgs_pkg::SQ_W-1:0]          sq_result;
    logic                               hit;
    logic                               idx_ok;
    logic                               ram_we;
    logic                               ram_re;
    logic [vcgs_pkg::COORD_W-1:0]       ram_raddr;
    logic [vcgs_pkg::GRID_SIDE-1:0]     ram_wdata;
    logic [vcgs_pkg::GRID_SIDE-1:0]     ram_rdata;

    // first covered cell, clipped at the low edge
    function automatic logic [vcgs_pkg::CRD_W-1:0] range_lo(
        input logic signed [vcgs_pkg::E_W-1:0] a
    );
        logic [vcgs_pkg::Q_W-1:0] q;
        q = a[vcgs_pkg::E_W-1:vcgs_pkg::FRAC_SHIFT];
        if (a[vcgs_pkg::E_W-1]) begin
            return '0;
        end else if (q >= vcgs_pkg::Q_W'(vcgs_pkg::GRID_SIDE)) begin
            return vcgs_pkg::CRD_W'(vcgs_pkg::GRID_SIDE);
        end else begin
            return q[vcgs_pkg::CRD_W-1:0];
        end
    endfunction

    // last covered cell plus one, clipped at the high edge
    function automatic logic [vcgs_pkg::CRD_W-1:0] range_hi(
        input logic signed [vcgs_pkg::E_W-1:0] b
    );
        logic [vcgs_pkg::Q_W-1:0] q;
        q = b[vcgs_pkg::E_W-1:vcgs_pkg::FRAC_SHIFT];
        if (b[vcgs_pkg::E_W-1]) begin
            return '0;
        end else if (q >= vcgs_pkg::Q_W'(vcgs_pkg::GRID_SIDE - 1)) begin
            return vcgs_pkg::CRD_W'(vcgs_pkg::GRID_SIDE - 1);
        end else begin
            return q[vcgs_pkg::CRD_W-1:0] + vcgs_pkg::CRD_W'(1);
        end
    endfunction

    // cell centre (2c + 1) / 2 in Q.24
    function automatic logic signed [vcgs_pkg::E_W-1:0] centre(
        input logic [vcgs_pkg::CRD_W-1:0] c
    );
        return signed'(vcgs_pkg::E_W'({c, 1'b1, {(vcgs_pkg::FRAC_SHIFT-1){1'b0}}}));
    endfunction

    // (e + 1 cell)^2 from e^2
    function automatic logic [vcgs_pkg::SQ_W-1:0] sq_step(
        input logic [vcgs_pkg::SQ_W-1:0]        sq,
        input logic signed [vcgs_pkg::E_W-1:0]  e
    );
        logic signed [vcgs_pkg::SQX_W-1:0] s_sq;
        logic signed [vcgs_pkg::SQX_W-1:0] s_e;
        logic signed [vcgs_pkg::SQX_W-1:0] t;
        s_sq = signed'({2'b00, sq});
        s_e  = vcgs_pkg::SQX_W'(e);
        t    = s_sq + (s_e <<< (vcgs_pkg::FRAC_SHIFT + 1)) + vcgs_pkg::SQ_STEP;
        return t[vcgs_pkg::SQ_W-1:0];
    endfunction

    always_comb begin
        unique case (i_cmd.g_sel)
            vcgs_pkg::G_X: op_a = vcgs_pkg::MUL_W'(r_px) - vcgs_pkg::MUL_W'(r_origin);
            vcgs_pkg::G_Z: op_a = vcgs_pkg::MUL_W'(r_pz) - vcgs_pkg::MUL_W'(r_origin);
            vcgs_pkg::G_R: op_a = vcgs_pkg::MUL_W'(r_rad);
            default:       op_a = '0;
        endcase
        op_b   = signed'({1'b0, r_inv});
        g_prod = vcgs_pkg::G_W'(op_a) * vcgs_pkg::G_W'(op_b);

        a_x = vcgs_pkg::E_W'(r_gx) - vcgs_pkg::E_W'(r_gr);
        b_x = vcgs_pkg::E_W'(r_gx) + vcgs_pkg::E_W'(r_gr);
        a_z = vcgs_pkg::E_W'(r_gz) - vcgs_pkg::E_W'(r_gr);
        b_z = vcgs_pkg::E_W'(r_gz) + vcgs_pkg::E_W'(r_gr);

        unique case (i_cmd.sq_sel)
            vcgs_pkg::SQ_R: sq_operand = vcgs_pkg::E_W'(r_gr);
            vcgs_pkg::SQ_X: sq_operand = r_ex0;
            vcgs_pkg::SQ_Z: sq_operand = r_ez;
            default:        sq_operand = '0;
        endcase

        hit    = signed'({1'b0, r_sqx}) <= r_slack;
        idx_ok = {1'b0, r_idx} < vcgs_pkg::IDX_LIM_W'(vcgs_pkg::CELL_COUNT);

        ram_we    = i_cmd.clr_wr | i_cmd.row_wr;
        ram_wdata = i_cmd.clr_wr ? '0 : r_row;
        ram_re    = i_cmd.row_rd | i_cmd.rd_issue;
        ram_raddr = i_cmd.rd_issue ? r_idx[vcgs_pkg::COORD_W +: vcgs_pkg::COORD_W]
                                   : r_z[vcgs_pkg::COORD_W-1:0];
    end

    vcgs_sq u_sq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.sq_start),
        .i_operand (sq_operand),
        .o_busy    (sq_busy),
        .o_done    (sq_done),
        .o_square  (sq_result)
    );

    // one word per grid row
    vcgs_ram #(
        .WIDTH (vcgs_pkg::GRID_SIDE),
        .DEPTH (vcgs_pkg::GRID_SIDE)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_z[vcgs_pkg::COORD_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin    <= '0;
            r_inv       <= vcgs_pkg::INV_RESET;
            r_count     <= '0;
            r_z         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    vcgs_pkg::CFG_ORIGIN: r_origin <= signed'(i_cfg_wdata);
                    vcgs_pkg::CFG_INV:    r_inv    <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            if (i_cmd.load) begin
                if (i_in_data.req_type == vcgs_pkg::REQ_CLEAR) begin
                    r_count <= '0;
                end else if (i_in_data.req_type == vcgs_pkg::REQ_STAMP && o_status.stamp_ok &&
                             r_count != vcgs_pkg::COUNT_MAX) begin
                    r_count <= r_count + vcgs_pkg::CNT_W'(1);
                end
            end

            priority if (i_cmd.load) begin
                r_z <= '0;
            end else if (i_cmd.prep_en) begin
                r_z <= r_z0;
            end else if (i_cmd.clr_wr || i_cmd.z_next) begin
                r_z <= r_z + vcgs_pkg::CRD_W'(1);
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_in_data.pos_x;
            r_pz   <= i_in_data.pos_z;
            r_rad  <= i_in_data.sight_radius;
            r_idx  <= i_in_data.cell_index;
            r_cell <= 1'b0;
        end

        if (i_cmd.g_en) begin
            unique case (i_cmd.g_sel)
                vcgs_pkg::G_X: r_gx <= g_prod;
                vcgs_pkg::G_Z: r_gz <= g_prod;
                vcgs_pkg::G_R: r_gr <= g_prod;
                default: begin
                end
            endcase
        end

        if (i_cmd.range_en) begin
            r_x0  <= range_lo(a_x);
            r_x1  <= range_hi(b_x);
            r_z0  <= range_lo(a_z);
            r_z1  <= range_hi(b_z);
            r_neg <= b_x[vcgs_pkg::E_W-1] | b_z[vcgs_pkg::E_W-1];
        end

        if (i_cmd.prep_en) begin
            r_ex0 <= centre(r_x0) - vcgs_pkg::E_W'(r_gx);
            r_ez  <= centre(r_z0) - vcgs_pkg::E_W'(r_gz);
        end

        if (i_cmd.sq_start) begin
            r_sq_dst <= i_cmd.sq_sel;
        end

        if (sq_done) begin
            unique case (r_sq_dst)
                vcgs_pkg::SQ_R: r_rsq  <= sq_result;
                vcgs_pkg::SQ_X: r_sqx0 <= sq_result;
                vcgs_pkg::SQ_Z: r_sqz  <= sq_result;
                default: begin
                end
            endcase
        end

        if (i_cmd.row_rd) begin
            r_x   <= r_x0;
            r_sqx <= r_sqx0;
            r_ex  <= r_ex0;
        end

        if (i_cmd.row_load) begin
            r_row   <= ram_rdata;
            r_slack <= signed'({1'b0, r_rsq}) - signed'({1'b0, r_sqz});
        end

        if (i_cmd.cell_en) begin
            if (hit) begin
                r_row[r_x[vcgs_pkg::COORD_W-1:0]] <= 1'b1;
            end
            r_x   <= r_x + vcgs_pkg::CRD_W'(1);
            r_sqx <= sq_step(r_sqx, r_ex);
            r_ex  <= r_ex + vcgs_pkg::E_STEP;
        end

        if (i_cmd.z_next) begin
            r_sqz <= sq_step(r_sqz, r_ez);
            r_ez  <= r_ez + vcgs_pkg::E_STEP;
        end

        if (i_cmd.rd_load) begin
            r_cell <= idx_ok & ram_rdata[r_idx[vcgs_pkg::COORD_W-1:0]];
        end

        if (i_cmd.out_load) begin
            r_out.cell_value   <= r_cell ? vcgs_pkg::CELL_ON : vcgs_pkg::CELL_OFF;
            r_out.source_count <= r_count;
        end
    end

    always_comb begin
        o_status.req        = i_in_data.req_type;
        o_status.stamp_ok   = (i_in_data.team_id == 8'd0) && (i_in_data.sight_radius > 0);
        o_status.empty      = r_neg | (r_x0 > r_x1) | (r_z0 > r_z1);
        o_status.sq_done    = sq_done;
        o_status.x_last     = (r_x == r_x1);
        o_status.z_last     = (r_z == r_z1);
        o_status.sweep_last = (r_z == vcgs_pkg::CRD_W'(vcgs_pkg::GRID_SIDE - 1));
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `VCGS_ASSERT_IMPL(a_row_wr_in_box, i_clk, i_rst_n, i_cmd.row_wr, r_z >= r_z0 && r_z <= r_z1)
    `VCGS_ASSERT_IMPL(a_cell_in_box, i_clk, i_rst_n, i_cmd.cell_en, r_x >= r_x0 && r_x <= r_x1)
    `VCGS_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || !i_out_stall)
    `VCGS_ASSERT_IMPL(a_sq_start_idle, i_clk, i_rst_n, i_cmd.sq_start, !sq_busy)

endmodule

// ===== rtl/vcgs_ctrl.sv =====
`timescale 1ns / 1ps

module vcgs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  vcgs_pkg::t_dp_status  i_status,
    output vcgs_pkg::t_dp_cmd     o_cmd
);

    vcgs_pkg::t_state r_state;
    vcgs_pkg::t_state n_state;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcgs_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.g_sel  = vcgs_pkg::G_X;
        o_cmd.sq_sel = vcgs_pkg::SQ_R;
        n_state      = r_state;
        o_in_stall   = (r_state != vcgs_pkg::ST_IDLE);
        accept       = i_in_valid && (r_state == vcgs_pkg::ST_IDLE);

        unique case (r_state)
            vcgs_pkg::ST_INIT: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = vcgs_pkg::ST_IDLE;
                end
            end
            vcgs_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    priority if (i_status.req == vcgs_pkg::REQ_CLEAR) begin
                        n_state = vcgs_pkg::ST_CLEAR;
                    end else if (i_status.req == vcgs_pkg::REQ_STAMP && i_status.stamp_ok) begin
                        n_state = vcgs_pkg::ST_GMUL_X;
                    end else if (i_status.req == vcgs_pkg::REQ_READ) begin
                        n_state = vcgs_pkg::ST_READ;
                    end else begin
                        n_state = vcgs_pkg::ST_DONE;
                    end
                end
            end
            vcgs_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.sweep_last) begin
                    n_state = vcgs_pkg::ST_DONE;
                end
            end
            vcgs_pkg::ST_GMUL_X: begin
                o_cmd.g_en  = 1'b1;
                o_cmd.g_sel = vcgs_pkg::G_X;
                n_state     = vcgs_pkg::ST_GMUL_Z;
            end
            vcgs_pkg::ST_GMUL_Z: begin
                o_cmd.g_en  = 1'b1;
                o_cmd.g_sel = vcgs_pkg::G_Z;
                n_state     = vcgs_pkg::ST_GMUL_R;
            end
            vcgs_pkg::ST_GMUL_R: begin
                o_cmd.g_en  = 1'b1;
                o_cmd.g_sel = vcgs_pkg::G_R;
                n_state     = vcgs_pkg::ST_RANGE;
            end
            vcgs_pkg::ST_RANGE: begin
                o_cmd.range_en = 1'b1;
                n_state        = vcgs_pkg::ST_CHECK;
            end
            vcgs_pkg::ST_CHECK: begin
                o_cmd.prep_en = 1'b1;
                if (i_status.empty) begin
                    n_state = vcgs_pkg::ST_DONE;
                end else begin
                    o_cmd.sq_start = 1'b1;
                    o_cmd.sq_sel   = vcgs_pkg::SQ_R;
                    n_state        = vcgs_pkg::ST_SQ_R;
                end
            end
            vcgs_pkg::ST_SQ_R: begin
                if (i_status.sq_done) begin
                    o_cmd.sq_start = 1'b1;
                    o_cmd.sq_sel   = vcgs_pkg::SQ_X;
                    n_state        = vcgs_pkg::ST_SQ_X;
                end
            end
            vcgs_pkg::ST_SQ_X: begin
                if (i_status.sq_done) begin
                    o_cmd.sq_start = 1'b1;
                    o_cmd.sq_sel   = vcgs_pkg::SQ_Z;
                    n_state        = vcgs_pkg::ST_SQ_Z;
                end
            end
            vcgs_pkg::ST_SQ_Z: begin
                if (i_status.sq_done) begin
                    n_state = vcgs_pkg::ST_ROW_RD;
                end
            end
            vcgs_pkg::ST_ROW_RD: begin
                o_cmd.row_rd = 1'b1;
                n_state      = vcgs_pkg::ST_ROW_WAIT;
            end
            vcgs_pkg::ST_ROW_WAIT: begin
                o_cmd.row_load = 1'b1;
                n_state        = vcgs_pkg::ST_CELL;
            end
            vcgs_pkg::ST_CELL: begin
                o_cmd.cell_en = 1'b1;
                if (i_status.x_last) begin
                    n_state = vcgs_pkg::ST_ROW_WR;
                end
            end
            vcgs_pkg::ST_ROW_WR: begin
                o_cmd.row_wr = 1'b1;
                if (i_status.z_last) begin
                    n_state = vcgs_pkg::ST_DONE;
                end else begin
                    o_cmd.z_next = 1'b1;
                    n_state      = vcgs_pkg::ST_ROW_RD;
                end
            end
            vcgs_pkg::ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = vcgs_pkg::ST_READ_WAIT;
            end
            vcgs_pkg::ST_READ_WAIT: begin
                o_cmd.rd_load = 1'b1;
                n_state       = vcgs_pkg::ST_DONE;
            end
            vcgs_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = vcgs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = vcgs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/vision_circle_grid_stamper.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake                      payload
// input     in         i_in_valid / o_in_stall        i_in_data   (vcgs_pkg::t_in)
// output    out        o_out_valid / i_out_stall      o_out_data  (vcgs_pkg::t_out)
// config    in         i_cfg_wr_en                    i_cfg_index, i_cfg_wdata
//
// the row walk sets the stamp time: one cell per cycle, a row read and write per row
// reset: a clearing pass writes all GRID_SIDE rows, one per cycle, before any input
// stalls: the result sits in an output register while the next input transaction
//   is taken; a new result waits until that register frees up

module vision_circle_grid_stamper (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  vcgs_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output vcgs_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_wr_en,
    input  logic [vcgs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vcgs_pkg::VAL_W-1:0]      i_cfg_wdata
);

    // command and status between sequencer and datapath
    vcgs_pkg::t_dp_cmd    cmd;
    vcgs_pkg::t_dp_status status;

    // sequencer: clear sweep, stamp setup, row walk and read
    vcgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: grid mapping, squares, row memory and output register
    vcgs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

    // run limit, generous against the slowest correct run
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int LONG_HOLD   = 400;

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // block-facing signals, all inputs known from time zero
    logic                                in_valid   = 1'b0;
    logic                                in_stall;
    vcgs_pkg::t_in                       in_data    = '0;
    logic                                out_valid;
    logic                                out_stall  = 1'b0;
    vcgs_pkg::t_out                      out_data;
    logic                                cfg_wr_en  = 1'b0;
    logic [vcgs_pkg::CFG_IDX_W-1:0]      cfg_index  = vcgs_pkg::CFG_ORIGIN;
    logic [vcgs_pkg::VAL_W-1:0]          cfg_wdata  = '0;

    vision_circle_grid_stamper u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // requests waiting to be driven, replies waiting to be seen
    vcgs_pkg::t_in  req_queue[$];
    vcgs_pkg::t_out reply_queue[$];

    // shadow of the block: bitmap, source counter and both registers
    bit                         vis_map [0:vcgs_pkg::CELL_COUNT-1];
    logic [vcgs_pkg::CNT_W-1:0] src_count  = '0;
    longint                     cfg_origin = 0;
    longint                     cfg_inv    = 65536;

    // idling controls, set per phase by the stimulus process
    bit     tx_idle_on = 1'b1;
    bit     rx_idle_on = 1'b1;
    int     hold_at    = -1;
    int     accepted_in = 0;
    int     err_count  = 0;

    // last stamped circle, so reads can land around it (in cells)
    int     last_cx = 64;
    int     last_cz = 64;
    int     last_rc = 4;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // random idle length: mostly short, a few long
    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 70) begin
            return $urandom_range(1, 3);
        end else if (p < 95) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 80);
    endfunction

    // inclusive cell span of [c - r, c + r] in Q.24, clipped to the grid
    function automatic bit cell_span(input longint c, input longint r,
                                     output int lo, output int hi);
        longint a;
        longint b;
        longint h;
        a  = c - r;
        b  = c + r;
        lo = 0;
        hi = 0;
        if (b < 0) begin
            return 1'b0;
        end
        if (a < 0) begin
            lo = 0;
        end else begin
            lo = ((a >> 24) < vcgs_pkg::GRID_SIDE) ? int'(a >> 24) : vcgs_pkg::GRID_SIDE;
        end
        h = (b >> 24) + 1;
        if (h > vcgs_pkg::GRID_SIDE - 1) begin
            h = vcgs_pkg::GRID_SIDE - 1;
        end
        hi = int'(h);
        return lo <= hi;
    endfunction

    // mark every cell whose centre is within the radius, exact 128-bit compare
    function automatic void stamp_circle(input longint px, input longint pz,
                                         input longint rad);
        longint       gx;
        longint       gz;
        longint       gr;
        longint       diff;
        logic [127:0] rsq;
        logic [127:0] dz2;
        logic [127:0] dxw;
        logic [127:0] dzw;
        int           x0;
        int           x1;
        int           z0;
        int           z1;
        gx  = (px - cfg_origin) * cfg_inv;
        gz  = (pz - cfg_origin) * cfg_inv;
        gr  = rad * cfg_inv;
        dxw = gr;
        rsq = dxw * dxw;
        if (!cell_span(gx, gr, x0, x1)) begin
            return;
        end
        if (!cell_span(gz, gr, z0, z1)) begin
            return;
        end
        for (int z = z0; z <= z1; z++) begin
            diff = (longint'(2 * z + 1) <<< 23) - gz;
            dzw  = (diff < 0) ? -diff : diff;
            dz2  = dzw * dzw;
            for (int x = x0; x <= x1; x++) begin
                diff = (longint'(2 * x + 1) <<< 23) - gx;
                dxw  = (diff < 0) ? -diff : diff;
                if (dxw * dxw + dz2 <= rsq) begin
                    vis_map[z * vcgs_pkg::GRID_SIDE + x] = 1'b1;
                end
            end
        end
    endfunction

    // advance the shadow by one accepted request and queue its reply
    function automatic void visibility_step(input vcgs_pkg::t_in tr);
        vcgs_pkg::t_out res;
        longint         rad;
        res.cell_value = vcgs_pkg::CELL_OFF;
        case (vcgs_pkg::t_req'(tr.req_type))
            vcgs_pkg::REQ_CLEAR: begin
                foreach (vis_map[i]) vis_map[i] = 1'b0;
                src_count = '0;
            end
            vcgs_pkg::REQ_STAMP: begin
                rad = longint'($signed(tr.sight_radius));
                if (tr.team_id == 8'd0 && rad > 0) begin
                    if (src_count != vcgs_pkg::COUNT_MAX) begin
                        src_count = src_count + vcgs_pkg::CNT_W'(1);
                    end
                    stamp_circle(longint'($signed(tr.pos_x)),
                                 longint'($signed(tr.pos_z)), rad);
                end
            end
            vcgs_pkg::REQ_READ: begin
                if (int'(tr.cell_index) < vcgs_pkg::CELL_COUNT && vis_map[tr.cell_index]) begin
                    res.cell_value = vcgs_pkg::CELL_ON;
                end
            end
            default: ;
        endcase
        res.source_count = src_count;
        reply_queue.push_back(res);
    endfunction

    // request builders; unused fields carry random bits so every bit toggles
    function automatic vcgs_pkg::t_in noise_fields();
        vcgs_pkg::t_in tr;
        tr.req_type     = 2'($urandom);
        tr.pos_x        = vcgs_pkg::VAL_W'($urandom);
        tr.pos_z        = vcgs_pkg::VAL_W'($urandom);
        tr.sight_radius = vcgs_pkg::VAL_W'($urandom);
        tr.team_id      = 8'($urandom);
        tr.cell_index   = vcgs_pkg::IDX_W'($urandom);
        return tr;
    endfunction

    function automatic vcgs_pkg::t_in stamp_req(input longint px, input longint pz,
                                                input longint rad, input logic [7:0] team);
        vcgs_pkg::t_in tr;
        tr              = noise_fields();
        tr.req_type     = vcgs_pkg::REQ_STAMP;
        tr.pos_x        = vcgs_pkg::VAL_W'(px);
        tr.pos_z        = vcgs_pkg::VAL_W'(pz);
        tr.sight_radius = vcgs_pkg::VAL_W'(rad);
        tr.team_id      = team;
        return tr;
    endfunction

    function automatic vcgs_pkg::t_in read_req(input int idx);
        vcgs_pkg::t_in tr;
        tr            = noise_fields();
        tr.req_type   = vcgs_pkg::REQ_READ;
        tr.cell_index = vcgs_pkg::IDX_W'(idx);
        return tr;
    endfunction

    // clear and no-op with every other field set to all ones
    function automatic vcgs_pkg::t_in ctl_req(input vcgs_pkg::t_req op);
        vcgs_pkg::t_in tr;
        tr          = '1;
        tr.req_type = op;
        return tr;
    endfunction

    // grid position in Q.8 cells to a world coordinate under the current registers
    function automatic longint world_from_grid(input longint gq8);
        longint w;
        w = cfg_origin + (gq8 * 65536) / cfg_inv;
        if (w > 8388607) w = 8388607;
        if (w < -8388608) w = -8388608;
        return w;
    endfunction

    function automatic longint radius_from_cells(input longint rq8);
        longint r;
        r = (rq8 * 65536) / cfg_inv;
        if (r > 8388607) r = 8388607;
        if (r < 1) r = 1;
        return r;
    endfunction

    function automatic int clamp_cell(input int v);
        if (v < 0) return 0;
        if (v > vcgs_pkg::GRID_SIDE - 1) return vcgs_pkg::GRID_SIDE - 1;
        return v;
    endfunction

    // random traffic: stamps followed by reads around them, some noise
    task automatic push_random_items(input int n);
        vcgs_pkg::t_in tr;
        int            sel;
        int            p;
        int            dx;
        int            dz;
        longint        cxq;
        longint        czq;
        longint        rq;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                tr = noise_fields();
                tr.req_type = vcgs_pkg::REQ_CLEAR;
            end else if (sel < 43) begin
                cxq = longint'($urandom_range(0, 168 * 256)) - 20 * 256;
                czq = longint'($urandom_range(0, 168 * 256)) - 20 * 256;
                p   = $urandom_range(0, 999);
                // mostly small circles, a few large ones that can span much of the grid
                if (p < 15) begin
                    rq = $urandom_range(30 * 256, 100 * 256);
                end else if (p < 135) begin
                    rq = $urandom_range(8 * 256, 20 * 256);
                end else begin
                    rq = $urandom_range(1, 8 * 256);
                end
                tr = stamp_req(world_from_grid(cxq), world_from_grid(czq),
                               radius_from_cells(rq), 8'd0);
                last_cx = int'(cxq / 256);
                last_cz = int'(czq / 256);
                last_rc = int'(rq / 256) + 2;
            end else if (sel < 51) begin
                // stamps that must be skipped: foreign team or radius not positive
                if ($urandom_range(0, 1) == 0) begin
                    tr = noise_fields();
                    tr.req_type = vcgs_pkg::REQ_STAMP;
                    tr.team_id  = 8'($urandom_range(1, 255));
                end else begin
                    tr = stamp_req($urandom, $urandom,
                                   -longint'($urandom_range(0, 8388608)), 8'd0);
                end
            end else if (sel < 96) begin
                if ($urandom_range(0, 99) < 60) begin
                    dx = $urandom_range(0, 2 * last_rc) - last_rc;
                    dz = $urandom_range(0, 2 * last_rc) - last_rc;
                    tr = read_req(clamp_cell(last_cz + dz) * vcgs_pkg::GRID_SIDE
                                  + clamp_cell(last_cx + dx));
                end else begin
                    tr = read_req($urandom_range(0, vcgs_pkg::CELL_COUNT - 1));
                end
            end else begin
                tr = noise_fields();
                tr.req_type = vcgs_pkg::REQ_NOP;
            end
            req_queue.push_back(tr);
        end
    endtask

    // sender pauses here until every reply is in, then lets the block settle
    task automatic wait_drained();
        do @(negedge clk);
        while (req_queue.size() != 0 || in_valid || reply_queue.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [vcgs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vcgs_pkg::VAL_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == vcgs_pkg::CFG_ORIGIN) begin
            cfg_origin = longint'($signed(val));
        end else begin
            cfg_inv = longint'(val);
        end
    endtask

    // driver: predicts on every accepted transaction, then offers the next request
    int tx_gap = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                visibility_step(in_data);
                accepted_in <= accepted_in + 1;
            end
            // payload only moves once the current one is taken
            if (!in_valid || !in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end else if (req_queue.size() != 0) begin
                    in_data  <= req_queue.pop_front();
                    in_valid <= 1'b1;
                    tx_gap = (tx_idle_on && $urandom_range(0, 99) < 30) ? idle_len() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: random short stalls plus one long hold-off counted here
    int  rx_left   = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (!hold_done && hold_at >= 0 && accepted_in >= hold_at) begin
            // block fills up behind this and must stall its input
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            out_stall <= 1'b1;
        end else if (rx_left > 0) begin
            rx_left--;
            out_stall <= 1'b1;
        end else if (rx_idle_on && $urandom_range(0, 99) < 20) begin
            rx_left = idle_len() - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor: every accepted result against the oldest expected reply
    always @(posedge clk) begin : result_check
        vcgs_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (reply_queue.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", out_data));
            end else begin
                want = reply_queue.pop_front();
                if (out_data.cell_value !== want.cell_value) begin
                    report_mismatch($sformatf("cell_value got %h want %h",
                                              out_data.cell_value, want.cell_value));
                end
                if (out_data.source_count !== want.source_count) begin
                    report_mismatch($sformatf("source_count got %h want %h",
                                              out_data.source_count, want.source_count));
                end
            end
        end
    end

    // watchdog
    int cycle_count = 0;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("vision_circle_grid_stamper regression: fail");
            $finish;
        end
    end

    // stimulus: directed cases, then random phases per register setting
    initial begin
        longint origins [6];
        longint invs    [6];

        foreach (vis_map[i]) vis_map[i] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // default registers: one cell per 256 world units, grid edge at zero
        req_queue.push_back(read_req(0));
        // circle centred on cell (64, 64), radius 3: cells at exactly 3 are inside
        req_queue.push_back(stamp_req(16512, 16512, 768, 8'd0));
        req_queue.push_back(read_req(64 * vcgs_pkg::GRID_SIDE + 64));
        req_queue.push_back(read_req(64 * vcgs_pkg::GRID_SIDE + 67));
        req_queue.push_back(read_req(64 * vcgs_pkg::GRID_SIDE + 68));
        req_queue.push_back(read_req(61 * vcgs_pkg::GRID_SIDE + 64));
        // foreign team and non-positive radii leave bitmap and count alone
        req_queue.push_back(stamp_req(16512, 16512, 4096, 8'hFF));
        req_queue.push_back(stamp_req(16512, 16512, 0, 8'd0));
        req_queue.push_back(stamp_req(16512, 16512, -8388608, 8'd0));
        req_queue.push_back(read_req(64 * vcgs_pkg::GRID_SIDE + 70));
        // partly off the grid at the low x, high z corner
        req_queue.push_back(stamp_req(-512, 32640, 1024, 8'd0));
        req_queue.push_back(read_req(127 * vcgs_pkg::GRID_SIDE + 0));
        req_queue.push_back(read_req(127 * vcgs_pkg::GRID_SIDE + 2));
        // fully off the grid, still counted
        req_queue.push_back(stamp_req(-8388608, -8388608, 1, 8'd0));
        // extreme positions and radius, then one covering the whole grid
        req_queue.push_back(stamp_req(8388607, -8388608, 8388607, 8'd0));
        req_queue.push_back(stamp_req(0, 0, 8388607, 8'd0));
        req_queue.push_back(read_req(vcgs_pkg::CELL_COUNT - 1));
        req_queue.push_back(ctl_req(vcgs_pkg::REQ_NOP));
        req_queue.push_back(read_req(0));
        req_queue.push_back(ctl_req(vcgs_pkg::REQ_CLEAR));
        req_queue.push_back(read_req(0));
        req_queue.push_back(read_req(vcgs_pkg::CELL_COUNT - 1));
        wait_drained();

        // register settings, extremes among them
        origins[0] = 0;        invs[0] = 65536;
        origins[1] = -8388608; invs[1] = 16777215;
        origins[2] = 8388607;  invs[2] = 1;
        origins[3] = -1024;    invs[3] = 131072;
        origins[4] = longint'($urandom_range(0, 16777215)) - 8388608;
        invs[4]    = $urandom_range(16384, 262144);
        origins[5] = 2000;     invs[5] = 40000;

        for (int ph = 0; ph < 6; ph++) begin
            if (ph % 2 == 0) begin
                write_reg(vcgs_pkg::CFG_ORIGIN, vcgs_pkg::VAL_W'(origins[ph]));
                write_reg(vcgs_pkg::CFG_INV, vcgs_pkg::VAL_W'(invs[ph]));
            end else begin
                write_reg(vcgs_pkg::CFG_INV, vcgs_pkg::VAL_W'(invs[ph]));
                write_reg(vcgs_pkg::CFG_ORIGIN, vcgs_pkg::VAL_W'(origins[ph]));
            end
            // one phase runs with no idling at all
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            if (ph == 1) begin
                hold_at = accepted_in + 40;
            end
            push_random_items(310);
            wait_drained();
        end

        if (err_count == 0) begin
            $display("vision_circle_grid_stamper regression: pass");
        end else begin
            $display("vision_circle_grid_stamper regression: fail");
        end
        $finish;
    end

endmodule
